// ===== rtl/core/rrmd_pkg.sv =====
// rrmd_pkg: shared types and constants for the run-length row mask decoder.
// No dependencies; imported by the channel interfaces and all core modules.
package rrmd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROWS_W = 9;
  localparam int unsigned CNT_W  = 5;

  // Escape byte that opens and closes an explicit run list
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hFF;
  // Fill values of mask pixels
  localparam logic [BYTE_W-1:0] FILL_SET = 8'hFF;
  localparam logic [BYTE_W-1:0] FILL_CLR = 8'h00;

  // Register reset values
  localparam logic [BYTE_W-1:0] ROW_WIDTH_RST = 8'd96;
  localparam logic [BYTE_W-1:0] ROW_TOTAL_RST = 8'd64;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROW_WIDTH = 1'b0;
  localparam cfg_idx_t CFG_ROW_TOTAL = 1'b1;

  typedef enum logic [0:0] {
    KIND_BASE = 1'b0,
    KIND_RUN  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COMMAND = 2'd1,
    PH_RUNS    = 2'd2
  } phase_t;

  typedef enum logic [0:0] {
    CTL_IDLE = 1'b0,
    CTL_EMIT = 1'b1
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // decode the accepted byte
    logic advance;  // current result beat taken, step to the next
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;    // no result pending
    logic last;     // pending result is the final one of this byte
  } dp_stat_t;

endpackage

// ===== rtl/core/rrmd_if.sv =====
// rrmd_if: valid/ready channel interfaces for stream bytes and decoded runs.
// Depends on rrmd_pkg.
interface rrmd_in_if import rrmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rrmd_out_if import rrmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] value;
  logic [BYTE_W-1:0] run_length;
  logic              last;
  logic              image_done;

  modport source (output valid, output kind, output value, output run_length,
                  output last, output image_done, input ready);
  modport sink   (input valid, input kind, input value, input run_length,
                  input last, input image_done, output ready);
endinterface

// ===== rtl/core/rle_row_mask_decoder.sv =====
// rle_row_mask_decoder: top level of the run-length row mask decoder.
// Depends on rrmd_pkg, rrmd_if, rrmd_ctrl and rrmd_dp.
//
//   port     dir  kind           contents
//   in_bus   in   valid/ready    stream_byte
//   out_bus  out  valid/ready    kind, value, run_length, last, image_done
//   cfg_*    in   write only     0 row_width, 1 row_total
//
// One byte is in flight at a time: the byte is accepted, then its results
// go out one beat per cycle while out_bus is ready (one for a header or a
// byte inside a run list, none for the byte that opens a run list, up to 16
// for a repeat command). The result counter in the datapath sets that number.
// Reset is synchronous, active low, and restores all registers at once.
// Backpressure on out_bus holds the current beat; in_bus is not ready
// until the last beat of the current byte is taken.
module rle_row_mask_decoder import rrmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rrmd_in_if.sink           in_bus,
  rrmd_out_if.source        out_bus,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Handshake controller
  rrmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Decode datapath
  rrmd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_bus.stream_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_kind  (out_bus.kind),
    .res_value (out_bus.value),
    .res_len   (out_bus.run_length),
    .res_last  (out_bus.last),
    .res_done  (out_bus.image_done)
  );

endmodule

// ===== rtl/core/rrmd_ctrl.sv =====
// rrmd_ctrl: handshake controller; accepts one byte, then drains its results.
// Depends on rrmd_pkg.
module rrmd_ctrl import rrmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    unique case (state_r)
      CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CTL_EMIT;
        end
      end
      CTL_EMIT: begin
        out_valid = !stat.empty;
        if (stat.empty) begin
          state_nxt = CTL_IDLE;
        end else if (out_ready) begin
          cmd.advance = 1'b1;
          if (stat.last) begin
            state_nxt = CTL_IDLE;
          end
        end
      end
      default: begin
        state_nxt = CTL_IDLE;
      end
    endcase
  end

  // Never take a byte while results are being drained
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("byte accepted while results pending");

  // A load always moves to draining
  a_load_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready) else $error("ready after load");

  // Last beat returns to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && stat.last) |=> in_ready)
    else $error("not idle after last beat");

endmodule

// ===== rtl/core/rrmd_dp.sv =====
// rrmd_dp: decode datapath; image state, config registers and result sequencer.
// Depends on rrmd_pkg.
module rrmd_dp import rrmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  output logic              res_kind,
  output logic [BYTE_W-1:0] res_value,
  output logic [BYTE_W-1:0] res_len,
  output logic              res_last,
  output logic              res_done
);

  // Config registers
  logic [BYTE_W-1:0] row_width_r, row_total_r;

  // Image state
  phase_t                   phase_r, phase_nxt;
  logic [BYTE_W-1:0]        base_r, base_nxt;
  logic [BYTE_W-1:0]        fill_r, fill_nxt;
  logic [BYTE_W-1:0]        run_sum_r, run_sum_nxt;
  logic signed [ROWS_W-1:0] rows_left_r, rows_left_nxt;

  // Result sequencer
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              rep_r, rep_nxt;
  logic              kind_r, kind_nxt;
  logic [BYTE_W-1:0] value_r, value_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] ones_r, ones_nxt;
  logic [BYTE_W-1:0] zeros_r, zeros_nxt;
  logic              done_r, done_nxt;

  // Decode helpers
  logic [BYTE_W-1:0]        ones, zeros, pad;
  logic [3:0]               rep_rows, row_step;
  logic signed [ROWS_W-1:0] rows_dec;
  logic                     ends_image, is_esc;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      row_total_r <= ROW_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_WIDTH: row_width_r <= cfg_wdata;
        CFG_ROW_TOTAL: row_total_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Row arithmetic for the byte at the input
  always_comb begin
    is_esc     = (in_byte == ESC_BYTE);
    ones       = base_r + {3'b000, in_byte[4:0]};
    zeros      = (row_width_r > ones) ? (row_width_r - ones) : '0;
    pad        = (row_width_r > run_sum_r) ? (row_width_r - run_sum_r) : '0;
    rep_rows   = {1'b0, in_byte[7:5]} + 4'd1;
    row_step   = (phase_r == PH_COMMAND) ? rep_rows : 4'd1;
    rows_dec   = rows_left_r - $signed({5'b00000, row_step});
    ends_image = rows_dec[ROWS_W-1] || (rows_dec == '0);
  end

  // Load a byte or step through its results
  always_comb begin
    phase_nxt     = phase_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    run_sum_nxt   = run_sum_r;
    rows_left_nxt = rows_left_r;
    res_cnt_nxt   = res_cnt_r;
    rep_nxt       = rep_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    len_nxt       = len_r;
    ones_nxt      = ones_r;
    zeros_nxt     = zeros_r;
    done_nxt      = done_r;
    if (cmd.load) begin
      rep_nxt  = 1'b0;
      kind_nxt = KIND_RUN;
      done_nxt = 1'b0;
      unique case (phase_r)
        PH_HEADER: begin
          base_nxt      = in_byte;
          rows_left_nxt = $signed({1'b0, row_total_r});
          phase_nxt     = PH_COMMAND;
          kind_nxt      = KIND_BASE;
          value_nxt     = in_byte;
          len_nxt       = '0;
          res_cnt_nxt   = CNT_W'(1);
        end
        PH_COMMAND: begin
          if (is_esc) begin
            // Open explicit run list
            fill_nxt    = FILL_SET;
            run_sum_nxt = '0;
            phase_nxt   = PH_RUNS;
            res_cnt_nxt = '0;
          end else begin
            // Repeated rows: pairs of set and clear runs
            rows_left_nxt = rows_dec;
            phase_nxt     = ends_image ? PH_HEADER : PH_COMMAND;
            done_nxt      = ends_image;
            rep_nxt       = 1'b1;
            ones_nxt      = ones;
            zeros_nxt     = zeros;
            value_nxt     = FILL_SET;
            len_nxt       = ones;
            res_cnt_nxt   = {rep_rows, 1'b0};
          end
        end
        PH_RUNS: begin
          value_nxt   = fill_r;
          res_cnt_nxt = CNT_W'(1);
          if (is_esc) begin
            // Close the list, pad to row width
            len_nxt       = pad;
            rows_left_nxt = rows_dec;
            phase_nxt     = ends_image ? PH_HEADER : PH_COMMAND;
            done_nxt      = ends_image;
          end else begin
            len_nxt     = in_byte;
            run_sum_nxt = run_sum_r + in_byte;
            fill_nxt    = fill_r ^ FILL_SET;
          end
        end
        default: begin
          phase_nxt   = PH_HEADER;
          res_cnt_nxt = '0;
        end
      endcase
    end else if (cmd.advance) begin
      res_cnt_nxt = res_cnt_r - CNT_W'(1);
      // Alternate set and clear runs of a repeated row
      if (rep_r) begin
        if (value_r == FILL_SET) begin
          value_nxt = FILL_CLR;
          len_nxt   = zeros_r;
        end else begin
          value_nxt = FILL_SET;
          len_nxt   = ones_r;
        end
      end
    end
  end

  // Control and image state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      base_r      <= '0;
      fill_r      <= FILL_SET;
      run_sum_r   <= '0;
      rows_left_r <= '0;
      res_cnt_r   <= '0;
      rep_r       <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      fill_r      <= fill_nxt;
      run_sum_r   <= run_sum_nxt;
      rows_left_r <= rows_left_nxt;
      res_cnt_r   <= res_cnt_nxt;
      rep_r       <= rep_nxt;
      done_r      <= done_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_BASE;
      value_r <= '0;
      len_r   <= '0;
      ones_r  <= '0;
      zeros_r <= '0;
    end else begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      len_r   <= len_nxt;
      ones_r  <= ones_nxt;
      zeros_r <= zeros_nxt;
    end
  end

  assign stat.empty = (res_cnt_r == '0);
  assign stat.last  = (res_cnt_r == CNT_W'(1));
  assign res_kind   = kind_r;
  assign res_value  = value_r;
  assign res_len    = len_r;
  assign res_last   = stat.last;
  assign res_done   = done_r;

  // At most eight row pairs pending
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CNT_W'(16)) else $error("result count overflow");

  // Advance only with a result pending
  a_adv_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !stat.empty) else $error("advance with no result");

  // A finished image always expects a new header
  a_done_header: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !stat.empty) |-> (phase_r == PH_HEADER))
    else $error("image done without header phase");

endmodule

// ===== test/tb_rle_row_mask_decoder.sv =====
// tb_rle_row_mask_decoder: self-checking regression for the row mask decoder.
// Needs rrmd_pkg, rrmd_if and the rle_row_mask_decoder RTL; drives a table of
// directed bytes and then random streams, checking every beat against a predictor or typed-in beats.
`timescale 1ns / 100ps

module tb_rle_row_mask_decoder;
  import rrmd_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] run_length;
    logic              last;
    logic              image_done;
  } run_beat_t;

  typedef enum logic [1:0] {
    ACT_FEED,
    ACT_FEED_TYPED,
    ACT_WRITE
  } plan_act_t;

  typedef enum logic [1:0] {
    PACE_OPEN,
    PACE_LIGHT,
    PACE_HEAVY,
    PACE_TOGGLE
  } pace_t;

  typedef struct {
    plan_act_t         act;
    logic [BYTE_W-1:0] data;
    cfg_idx_t          reg_sel;
    run_beat_t         beat;
  } plan_row_t;

  localparam run_beat_t NO_BEAT = '{KIND_BASE, 8'h00, 8'h00, 1'b0, 1'b0};
  localparam int DIRECTED_ROWS = 27;
  localparam int ITEMS_PER_PHASE = 26;
  localparam int RANDOM_PHASES = 6;
  localparam int CHOKE_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;

  rrmd_in_if  in_bus();
  rrmd_out_if out_bus();

  rle_row_mask_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state and its copy of the registers
  phase_t            dec_phase;
  logic [BYTE_W-1:0] dec_base;
  logic [BYTE_W-1:0] dec_fill;
  logic [BYTE_W-1:0] dec_sum;
  int                dec_rows;
  logic [BYTE_W-1:0] cur_width;
  logic [BYTE_W-1:0] cur_total;

  run_beat_t row_beats[$];
  run_beat_t expected_runs[$];

  int error_count;
  int fed_count;
  int burst_left;
  bit stream_busy;
  bit choke_req;

  // Directed stimulus: expected beats typed in only where obvious
  plan_row_t directed_plan [0:DIRECTED_ROWS-1] = '{
    // reset geometry: 96 wide, 64 rows
    '{ACT_FEED_TYPED, 8'h00, CFG_ROW_WIDTH, '{KIND_BASE, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{ACT_FEED,       8'h00, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hFF, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED_TYPED, 8'h00, CFG_ROW_WIDTH, '{KIND_RUN, 8'hFF, 8'h00, 1'b1, 1'b0}},
    '{ACT_FEED_TYPED, 8'hFE, CFG_ROW_WIDTH, '{KIND_RUN, 8'h00, 8'hFE, 1'b1, 1'b0}},
    '{ACT_FEED,       8'h05, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hFF, CFG_ROW_WIDTH, NO_BEAT},
    // eight-row repeats run the counter below zero
    '{ACT_FEED,       8'hFE, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE0, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE1, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE2, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE3, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE4, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE5, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED,       8'hE6, CFG_ROW_WIDTH, NO_BEAT},
    // widest row, single-row image, base wraps with the low bits
    '{ACT_WRITE,      8'hFF, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_WRITE,      8'h01, CFG_ROW_TOTAL, NO_BEAT},
    '{ACT_FEED_TYPED, 8'hFF, CFG_ROW_WIDTH, '{KIND_BASE, 8'hFF, 8'h00, 1'b1, 1'b0}},
    '{ACT_FEED,       8'h1F, CFG_ROW_WIDTH, NO_BEAT},
    // empty rows and a zero row count
    '{ACT_WRITE,      8'h00, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_WRITE,      8'h00, CFG_ROW_TOTAL, NO_BEAT},
    '{ACT_FEED_TYPED, 8'h10, CFG_ROW_WIDTH, '{KIND_BASE, 8'h10, 8'h00, 1'b1, 1'b0}},
    '{ACT_FEED,       8'hFF, CFG_ROW_WIDTH, NO_BEAT},
    '{ACT_FEED_TYPED, 8'h10, CFG_ROW_WIDTH, '{KIND_RUN, 8'hFF, 8'h10, 1'b1, 1'b0}},
    '{ACT_FEED_TYPED, 8'hFF, CFG_ROW_WIDTH, '{KIND_RUN, 8'h00, 8'h00, 1'b1, 1'b1}},
    '{ACT_FEED_TYPED, 8'h20, CFG_ROW_WIDTH, '{KIND_BASE, 8'h20, 8'h00, 1'b1, 1'b0}},
    '{ACT_FEED,       8'h05, CFG_ROW_WIDTH, NO_BEAT}
  };

  // Count rows off the image; close it at zero or below
  function automatic bit retire_rows(input int n);
    dec_rows -= n;
    if (dec_rows <= 0) begin
      dec_phase = PH_HEADER;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Decode one stream byte into the beats it should produce
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] ones;
    logic [BYTE_W-1:0] zeros;
    logic [BYTE_W-1:0] pad;
    int reps;
    bit done;
    row_beats.delete();
    unique case (dec_phase)
      PH_HEADER: begin
        dec_base = b;
        dec_rows = int'(cur_total);
        dec_phase = PH_COMMAND;
        row_beats.push_back('{KIND_BASE, b, 8'h00, 1'b1, 1'b0});
      end
      PH_COMMAND: begin
        if (b == ESC_BYTE) begin
          dec_fill = FILL_SET;
          dec_sum = 8'h00;
          dec_phase = PH_RUNS;
        end else begin
          ones = dec_base + {3'b000, b[4:0]};
          zeros = (cur_width > ones) ? cur_width - ones : 8'h00;
          reps = int'(b[7:5]) + 1;
          done = retire_rows(reps);
          for (int r = 0; r < reps; r++) begin
            row_beats.push_back('{KIND_RUN, FILL_SET, ones, 1'b0, done});
            row_beats.push_back('{KIND_RUN, FILL_CLR, zeros, r == reps - 1, done});
          end
        end
      end
      default: begin
        if (b != ESC_BYTE) begin
          row_beats.push_back('{KIND_RUN, dec_fill, b, 1'b1, 1'b0});
          dec_sum = dec_sum + b;
          dec_fill = ~dec_fill;
        end else begin
          pad = (cur_width > dec_sum) ? cur_width - dec_sum : 8'h00;
          dec_phase = PH_COMMAND;
          done = retire_rows(1);
          row_beats.push_back('{KIND_RUN, dec_fill, pad, 1'b1, done});
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want_v);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want_v);
    error_count++;
  endtask

  // Hold the input quiet until every expected beat is out, then let it settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    stream_busy = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t sel, input logic [BYTE_W-1:0] data);
    if (stream_busy) wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    if (sel == CFG_ROW_WIDTH) cur_width = data;
    else cur_total = data;
  endtask

  // Offer one byte in bursts with random gaps; predict once it is taken
  task automatic put_byte(input logic [BYTE_W-1:0] b, input bit typed,
                          input run_beat_t typed_beat);
    int gap;
    if (cfg_we) cfg_we <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid <= 1'b1;
    in_bus.stream_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    fed_count++;
    stream_busy = 1'b1;
    decode_byte(b);
    if (typed) expected_runs.push_back(typed_beat);
    else foreach (row_beats[k]) expected_runs.push_back(row_beats[k]);
  endtask

  task automatic feed(input logic [BYTE_W-1:0] b);
    put_byte(b, 1'b0, NO_BEAT);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check each accepted beat against the oldest expectation
  always @(posedge clk) begin : beat_check
    run_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch("unexpected beat value", out_bus.value, 8'h00);
      end else begin
        want = expected_runs.pop_front();
        if (out_bus.kind !== want.kind)
          report_mismatch("kind", {7'd0, out_bus.kind}, {7'd0, want.kind});
        if (out_bus.value !== want.value)
          report_mismatch("value", out_bus.value, want.value);
        if (out_bus.run_length !== want.run_length)
          report_mismatch("run_length", out_bus.run_length, want.run_length);
        if (out_bus.last !== want.last)
          report_mismatch("last", {7'd0, out_bus.last}, {7'd0, want.last});
        if (out_bus.image_done !== want.image_done)
          report_mismatch("image_done", {7'd0, out_bus.image_done}, {7'd0, want.image_done});
      end
    end
  end

  // Receiver pacing, with one long hold-off on request
  initial begin : ready_pacer
    pace_t mode;
    int left;
    out_bus.ready <= 1'b0;
    mode = PACE_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (choke_req) begin
        choke_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = pace_t'($urandom_range(0, 3));
        left = $urandom_range(8, 64);
      end
      left--;
      unique case (mode)
        PACE_OPEN:  out_bus.ready <= 1'b1;
        PACE_LIGHT: out_bus.ready <= ($urandom_range(0, 3) != 0);
        PACE_HEAVY: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default:    out_bus.ready <= ~out_bus.ready;
      endcase
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("rle_row_mask_decoder regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] w;
    logic [BYTE_W-1:0] t;
    int phase_start;
    int pick;
    int nruns;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.stream_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROW_WIDTH;
    cfg_wdata <= 8'h00;
    error_count = 0;
    fed_count = 0;
    burst_left = 0;
    stream_busy = 1'b0;
    choke_req = 1'b0;
    cur_width = ROW_WIDTH_RST;
    cur_total = ROW_TOTAL_RST;
    dec_phase = PH_HEADER;
    dec_base = 8'h00;
    dec_fill = FILL_SET;
    dec_sum = 8'h00;
    dec_rows = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_plan[i]) begin
      unique case (directed_plan[i].act)
        ACT_WRITE:      write_reg(directed_plan[i].reg_sel, directed_plan[i].data);
        ACT_FEED_TYPED: put_byte(directed_plan[i].data, 1'b1, directed_plan[i].beat);
        default:        feed(directed_plan[i].data);
      endcase
    end

    // Random phases, each under its own row geometry
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      unique case (p)
        0: begin w = 8'd255; t = 8'd3; end
        1: begin w = 8'd0; t = 8'd1; end
        RANDOM_PHASES - 1: begin w = 8'($urandom_range(4, 160)); t = 8'd255; end
        default: begin
          w = 8'($urandom_range(4, 160));
          t = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
        end
      endcase
      write_reg(CFG_ROW_WIDTH, w);
      write_reg(CFG_ROW_TOTAL, t);
      if (p == 2) choke_req = 1'b1;
      phase_start = fed_count;
      while (fed_count - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (dec_phase == PH_HEADER) begin
          feed(8'($urandom_range(0, 255)));
        end else if (pick < 5) begin
          // repeat command
          feed(8'($urandom_range(0, 254)));
        end else if (pick < 8) begin
          // explicit run list, properly closed
          feed(ESC_BYTE);
          nruns = $urandom_range(0, 5);
          repeat (nruns) feed(8'($urandom_range(0, 254)));
          feed(ESC_BYTE);
        end else if (pick == 8) begin
          feed(8'($urandom_range(0, 255)));
        end else begin
          // open a list and leave it unterminated
          feed(ESC_BYTE);
          repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 254)));
        end
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0 && expected_runs.size() == 0)
      $display("rle_row_mask_decoder regression: pass");
    else
      $display("rle_row_mask_decoder regression: fail");
    $finish;
  end

endmodule
